FILE: rtl/adp_pkg.sv
// adp_pkg: request/response payload types and opcode, condition and shift codes
// for the data-processing alu; no dependencies
`default_nettype none

package adp_pkg;

   // one decoded data-processing instruction
   typedef struct packed {
      logic [3:0]  cond;
      logic [3:0]  opcode;
      logic        s_bit;
      logic [3:0]  rn;
      logic [3:0]  rd;
      logic        imm_form;
      logic [11:0] operand2;
   } req_type;

   // outcome of one instruction
   typedef struct packed {
      logic        cond_passed;
      logic [31:0] result;
      logic [3:0]  dest;
      logic        reg_written;
      logic        flag_n;
      logic        flag_z;
      logic        flag_c;
      logic        flag_v;
      logic        pc_written;
   } rsp_type;

   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_ADC = 4'd5;
   localparam logic [3:0] OP_SBC = 4'd6;
   localparam logic [3:0] OP_RSC = 4'd7;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_CMN = 4'd11;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;
   localparam logic [3:0] OP_BIC = 4'd14;
   localparam logic [3:0] OP_MVN = 4'd15;

   localparam logic [3:0] COND_EQ = 4'd0;
   localparam logic [3:0] COND_NE = 4'd1;
   localparam logic [3:0] COND_CS = 4'd2;
   localparam logic [3:0] COND_CC = 4'd3;
   localparam logic [3:0] COND_MI = 4'd4;
   localparam logic [3:0] COND_PL = 4'd5;
   localparam logic [3:0] COND_VS = 4'd6;
   localparam logic [3:0] COND_VC = 4'd7;
   localparam logic [3:0] COND_HI = 4'd8;
   localparam logic [3:0] COND_LS = 4'd9;
   localparam logic [3:0] COND_GE = 4'd10;
   localparam logic [3:0] COND_LT = 4'd11;
   localparam logic [3:0] COND_GT = 4'd12;
   localparam logic [3:0] COND_LE = 4'd13;
   localparam logic [3:0] COND_AL = 4'd14;

   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   localparam logic [3:0] PC_INDEX = 4'd15;

endpackage

`default_nettype wire

FILE: rtl/adp_exec.sv
// adp_exec: condition test, operand-2 barrel shifter, alu and flag logic
// depends on adp_pkg
`default_nettype none

module adp_exec (
   input  wire adp_pkg::req_type req,
   input  wire logic [31:0]      rn_val,
   input  wire logic [31:0]      rm_val,
   input  wire logic [31:0]      rs_val,
   input  wire logic [3:0]       nzcv,
   output adp_pkg::rsp_type      rsp
);

   logic        fn, fz, fc, fv;
   logic        passed;
   logic [4:0]  rot;
   logic [63:0] imm_rot;
   logic [1:0]  sh_type;
   logic        by_reg;
   logic [7:0]  amt;
   logic [4:0]  amt_lo;
   logic        amt_zero, amt_lt32, amt_eq32;
   logic        sign;
   logic [32:0] lsl_t, lsr_t;
   logic signed [32:0] asr_t;
   logic [63:0] ror_t;
   logic [31:0] op2;
   logic        sc;
   logic [31:0] add_x, add_y;
   logic        add_cin;
   logic [32:0] sum;
   logic        ovf;
   logic [31:0] r;
   logic        logical, writes, upd, wr;
   logic        new_c, new_v;

   assign fn = nzcv[3];
   assign fz = nzcv[2];
   assign fc = nzcv[1];
   assign fv = nzcv[0];

   always_comb begin
      case (req.cond)
         adp_pkg::COND_EQ: passed = fz;
         adp_pkg::COND_NE: passed = !fz;
         adp_pkg::COND_CS: passed = fc;
         adp_pkg::COND_CC: passed = !fc;
         adp_pkg::COND_MI: passed = fn;
         adp_pkg::COND_PL: passed = !fn;
         adp_pkg::COND_VS: passed = fv;
         adp_pkg::COND_VC: passed = !fv;
         adp_pkg::COND_HI: passed = fc && !fz;
         adp_pkg::COND_LS: passed = !fc || fz;
         adp_pkg::COND_GE: passed = (fn == fv);
         adp_pkg::COND_LT: passed = (fn != fv);
         adp_pkg::COND_GT: passed = !fz && (fn == fv);
         adp_pkg::COND_LE: passed = fz || (fn != fv);
         adp_pkg::COND_AL: passed = 1'b1;
         default:          passed = 1'b0;
      endcase
   end

   // operand 2
   assign rot      = {req.operand2[11:8], 1'b0};
   assign imm_rot  = {24'd0, req.operand2[7:0], 24'd0, req.operand2[7:0]} >> rot;
   assign sh_type  = req.operand2[6:5];
   assign by_reg   = req.operand2[4];
   assign amt      = by_reg ? rs_val[7:0] : {3'd0, req.operand2[11:7]};
   assign amt_lo   = amt[4:0];
   assign amt_zero = (amt == 8'd0);
   assign amt_lt32 = (amt < 8'd32);
   assign amt_eq32 = (amt == 8'd32);
   assign sign     = rm_val[31];
   assign lsl_t    = {1'b0, rm_val} << amt_lo;
   assign lsr_t    = {rm_val, 1'b0} >> amt_lo;
   assign asr_t    = $signed({rm_val, 1'b0}) >>> amt_lo;
   assign ror_t    = {rm_val, rm_val} >> amt_lo;

   always_comb begin
      op2 = rm_val;
      sc  = fc;
      if (req.imm_form) begin
         op2 = imm_rot[31:0];
         sc  = (rot == 5'd0) ? fc : imm_rot[31];
      end else if (amt_zero && !by_reg) begin
         // immediate amount zero encodes lsr/asr #32 and rrx
         case (sh_type)
            adp_pkg::SH_LSL: begin op2 = rm_val;            sc = fc;        end
            adp_pkg::SH_LSR: begin op2 = 32'd0;             sc = sign;      end
            adp_pkg::SH_ASR: begin op2 = {32{sign}};        sc = sign;      end
            default:         begin op2 = {fc, rm_val[31:1]}; sc = rm_val[0]; end
         endcase
      end else if (amt_zero) begin
         op2 = rm_val;
         sc  = fc;
      end else begin
         case (sh_type)
            adp_pkg::SH_LSL: begin
               if (amt_lt32) begin
                  op2 = lsl_t[31:0];
                  sc  = lsl_t[32];
               end else begin
                  op2 = 32'd0;
                  sc  = amt_eq32 ? rm_val[0] : 1'b0;
               end
            end
            adp_pkg::SH_LSR: begin
               if (amt_lt32) begin
                  op2 = lsr_t[32:1];
                  sc  = lsr_t[0];
               end else begin
                  op2 = 32'd0;
                  sc  = amt_eq32 ? sign : 1'b0;
               end
            end
            adp_pkg::SH_ASR: begin
               if (amt_lt32) begin
                  op2 = asr_t[32:1];
                  sc  = asr_t[0];
               end else begin
                  op2 = {32{sign}};
                  sc  = sign;
               end
            end
            default: begin
               // nonzero multiple of 32 passes rm through
               op2 = ror_t[31:0];
               sc  = (amt_lo == 5'd0) ? sign : ror_t[31];
            end
         endcase
      end
   end

   // adder operands
   always_comb begin
      add_x   = rn_val;
      add_y   = op2;
      add_cin = 1'b0;
      case (req.opcode)
         adp_pkg::OP_SUB, adp_pkg::OP_CMP: begin
            add_y = ~op2;  add_cin = 1'b1;
         end
         adp_pkg::OP_RSB: begin
            add_x = op2;   add_y = ~rn_val; add_cin = 1'b1;
         end
         adp_pkg::OP_ADC: begin
            add_cin = fc;
         end
         adp_pkg::OP_SBC: begin
            add_y = ~op2;  add_cin = fc;
         end
         adp_pkg::OP_RSC: begin
            add_x = op2;   add_y = ~rn_val; add_cin = fc;
         end
         default: begin
            add_cin = 1'b0;
         end
      endcase
   end

   assign sum = {1'b0, add_x} + {1'b0, add_y} + {32'd0, add_cin};
   assign ovf = ((add_x[31] ^ sum[31]) & (add_y[31] ^ sum[31]));

   always_comb begin
      logical = 1'b1;
      writes  = 1'b1;
      case (req.opcode)
         adp_pkg::OP_AND: r = rn_val & op2;
         adp_pkg::OP_EOR: r = rn_val ^ op2;
         adp_pkg::OP_TST: begin r = rn_val & op2; writes = 1'b0; end
         adp_pkg::OP_TEQ: begin r = rn_val ^ op2; writes = 1'b0; end
         adp_pkg::OP_ORR: r = rn_val | op2;
         adp_pkg::OP_MOV: r = op2;
         adp_pkg::OP_BIC: r = rn_val & ~op2;
         adp_pkg::OP_MVN: r = ~op2;
         adp_pkg::OP_CMP, adp_pkg::OP_CMN: begin
            r = sum[31:0]; logical = 1'b0; writes = 1'b0;
         end
         default: begin
            r = sum[31:0]; logical = 1'b0;
         end
      endcase
   end

   assign new_c = logical ? sc : sum[32];
   assign new_v = logical ? fv : ovf;
   assign upd   = passed && (req.s_bit || !writes);
   assign wr    = passed && writes;

   always_comb begin
      rsp.cond_passed = passed;
      rsp.result      = passed ? r : 32'd0;
      rsp.dest        = wr ? req.rd : 4'd0;
      rsp.reg_written = wr;
      rsp.flag_n      = upd ? r[31] : fn;
      rsp.flag_z      = upd ? (r == 32'd0) : fz;
      rsp.flag_c      = upd ? new_c : fc;
      rsp.flag_v      = upd ? new_v : fv;
      rsp.pc_written  = wr && (req.rd == adp_pkg::PC_INDEX);
   end

endmodule

`default_nettype wire

FILE: rtl/arm_data_processing_alu.sv
// arm_data_processing_alu: top level, request stage, register file, flags and
// response register; depends on adp_pkg and adp_exec
//
// usage
//  - req channel carries one decoded data-processing instruction per request
//    (req_valid/req_ready/req_data); rsp channel returns one outcome per
//    request (rsp_valid/rsp_ready/rsp_data), in order
//  - a request is taken into the execute stage at the edge it is accepted;
//    register operands are read from the register file at that same edge
//  - the instruction executes (condition, shifter, alu, flags, write-back) at
//    the next edge that the response register is free or being drained, so
//    rsp_valid rises as that edge loads the response register
//  - throughput is one request per cycle while rsp_ready stays high; a write-back in the same cycle as a
//    following read is bypassed, so dependent instructions run back to back
//  - when rsp_ready is low the response register holds, the execute stage
//    holds its request, and req_ready drops once the stage is full
//  - reset clears all sixteen registers (valid bits, entries read as zero
//    until written) and the nzcv flags, and empties both stages
`default_nettype none

module arm_data_processing_alu (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire adp_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output adp_pkg::rsp_type      rsp_data
);

   // execute stage
   logic             stg_valid_ff;
   adp_pkg::req_type stg_req_ff;

   // response register
   logic             rsp_valid_ff;
   adp_pkg::rsp_type rsp_ff;
   adp_pkg::rsp_type rsp_in;

   // register file: two copies so three operands can be read per request
   logic [31:0] regs_a_ff [16];
   logic [31:0] regs_b_ff [16];
   logic [15:0] vld_ff;

   // registered operand reads and bypass selects
   logic [31:0] rn_q_ff, rm_q_ff, rs_q_ff;
   logic        rn_vld_ff, rm_vld_ff, rs_vld_ff;
   logic        rn_byp_ff, rm_byp_ff, rs_byp_ff;
   logic [31:0] last_wr_ff;

   logic [3:0]  flags_ff;

   logic        req_fire, exec_fire, wr_en;
   logic [3:0]  wr_addr, rm_addr, rs_addr;
   logic [31:0] rn_val, rm_val, rs_val;

   // handshake
   assign exec_fire = stg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !stg_valid_ff || exec_fire;
   assign req_fire  = req_valid && req_ready;

   assign rm_addr = req_data.operand2[3:0];
   assign rs_addr = req_data.operand2[11:8];

   // write-back happens when the stage executes
   assign wr_en   = exec_fire && rsp_in.reg_written;
   assign wr_addr = rsp_in.dest;

   // operand values: bypass of the write made at the read edge, else the
   // stored entry, or zero for a never-written register
   assign rn_val = rn_byp_ff ? last_wr_ff : (rn_vld_ff ? rn_q_ff : 32'd0);
   assign rm_val = rm_byp_ff ? last_wr_ff : (rm_vld_ff ? rm_q_ff : 32'd0);
   assign rs_val = rs_byp_ff ? last_wr_ff : (rs_vld_ff ? rs_q_ff : 32'd0);

   adp_exec u_exec (
      .req    (stg_req_ff),
      .rn_val (rn_val),
      .rm_val (rm_val),
      .rs_val (rs_val),
      .nzcv   (flags_ff),
      .rsp    (rsp_in)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 16'd0;
         flags_ff     <= 4'd0;
         rn_vld_ff    <= 1'b0;
         rm_vld_ff    <= 1'b0;
         rs_vld_ff    <= 1'b0;
         rn_byp_ff    <= 1'b0;
         rm_byp_ff    <= 1'b0;
         rs_byp_ff    <= 1'b0;
      end else begin
         if (req_fire) begin
            stg_valid_ff <= 1'b1;
            rn_vld_ff    <= vld_ff[req_data.rn];
            rm_vld_ff    <= vld_ff[rm_addr];
            rs_vld_ff    <= vld_ff[rs_addr];
            rn_byp_ff    <= wr_en && (wr_addr == req_data.rn);
            rm_byp_ff    <= wr_en && (wr_addr == rm_addr);
            rs_byp_ff    <= wr_en && (wr_addr == rs_addr);
         end else if (exec_fire) begin
            stg_valid_ff <= 1'b0;
         end

         if (exec_fire) begin
            rsp_valid_ff <= 1'b1;
            flags_ff     <= {rsp_in.flag_n, rsp_in.flag_z, rsp_in.flag_c, rsp_in.flag_v};
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // payload and register file storage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_req_ff <= req_data;
         rn_q_ff    <= regs_a_ff[req_data.rn];
         rm_q_ff    <= regs_a_ff[rm_addr];
         rs_q_ff    <= regs_b_ff[rs_addr];
      end
      if (wr_en) begin
         regs_a_ff[wr_addr] <= rsp_in.result;
         regs_b_ff[wr_addr] <= rsp_in.result;
         last_wr_ff         <= rsp_in.result;
      end
      if (exec_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // flag register follows the flags reported with each executed request
   a_flags_track: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> (flags_ff == {rsp_ff.flag_n, rsp_ff.flag_z, rsp_ff.flag_c, rsp_ff.flag_v}))
      else $error("flag register differs from reported flags");

   // a failed condition leaves the flags alone
   a_cond_fail_hold: assert property (@(posedge clock) disable iff (reset)
      (exec_fire && !rsp_in.cond_passed) |=> $stable(flags_ff))
      else $error("flags changed on failed condition");

   // a waiting request in the stage is never lost or overwritten
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && !exec_fire) |=> (stg_valid_ff && $stable(stg_req_ff)))
      else $error("execute stage lost its request");

   // pc write implies a passed register write to r15
   a_pc_write: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.pc_written) |->
         (rsp_ff.reg_written && rsp_ff.cond_passed && rsp_ff.dest == adp_pkg::PC_INDEX))
      else $error("pc_written without write to r15");

   // a bypass select only comes from a write-back at the read edge
   a_bypass_src: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !wr_en) |=> (!rn_byp_ff && !rm_byp_ff && !rs_byp_ff))
      else $error("bypass selected without a write-back");

endmodule

`default_nettype wire
